[rtl/pc_pkg.sv]
`default_nettype none

package pc_pkg;

   localparam int CHAN_W  = 8;
   localparam int MODE_W  = 3;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int LANES   = 3;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   localparam logic [MODE_W-1:0] MODE_ALPHA   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD_SAT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DARKEN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INVERT  = 3'd4;

   localparam logic [2:0] REG_BLEND_MODE   = 3'd0;
   localparam logic [2:0] REG_ALPHA_WEIGHT = 3'd1;
   localparam logic [2:0] REG_USE_CONST    = 3'd2;
   localparam logic [2:0] REG_CONST_RED    = 3'd3;
   localparam logic [2:0] REG_CONST_GREEN  = 3'd4;
   localparam logic [2:0] REG_CONST_BLUE   = 3'd5;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic [MODE_W-1:0] blend_mode;
      chan_type          alpha_weight;
      logic              use_constant_colour;
      chan_type          const_red;
      chan_type          const_green;
      chan_type          const_blue;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/pc_if.sv]
`default_nettype none

interface pc_req_if;
   import pc_pkg::*;
   logic     valid;
   logic     ready;
   chan_type dst_red;
   chan_type dst_green;
   chan_type dst_blue;
   chan_type src_red;
   chan_type src_green;
   chan_type src_blue;

   modport source (
      output valid, dst_red, dst_green, dst_blue, src_red, src_green, src_blue,
      input  ready
   );
   modport sink (
      input  valid, dst_red, dst_green, dst_blue, src_red, src_green, src_blue,
      output ready
   );
endinterface

interface pc_rsp_if;
   import pc_pkg::*;
   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

`default_nettype wire

[rtl/pc_csr.sv]
`default_nettype none

module pc_csr
   import pc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_BLEND_MODE:   cfg_in.blend_mode          = pwdata[MODE_W-1:0];
            REG_ALPHA_WEIGHT: cfg_in.alpha_weight        = pwdata[CHAN_W-1:0];
            REG_USE_CONST:    cfg_in.use_constant_colour = pwdata[0];
            REG_CONST_RED:    cfg_in.const_red           = pwdata[CHAN_W-1:0];
            REG_CONST_GREEN:  cfg_in.const_green         = pwdata[CHAN_W-1:0];
            REG_CONST_BLUE:   cfg_in.const_blue          = pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BLEND_MODE:   prdata = DATA_W'(cfg_ff.blend_mode);
         REG_ALPHA_WEIGHT: prdata = DATA_W'(cfg_ff.alpha_weight);
         REG_USE_CONST:    prdata = DATA_W'(cfg_ff.use_constant_colour);
         REG_CONST_RED:    prdata = DATA_W'(cfg_ff.const_red);
         REG_CONST_GREEN:  prdata = DATA_W'(cfg_ff.const_green);
         REG_CONST_BLUE:   prdata = DATA_W'(cfg_ff.const_blue);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/pc_lane.sv]
`default_nettype none

module pc_lane
   import pc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [MODE_W-1:0] blend_mode,
   input  wire chan_type          alpha_weight,
   input  wire chan_type          dst,
   input  wire chan_type          src,
   output chan_type               result
);

   chan_type               result_ff;
   chan_type               result_in;
   logic [CHAN_W:0]        inv_weight;
   logic [2*CHAN_W:0]      blend_sum;
   logic [CHAN_W:0]        add_sum;

   assign inv_weight = (CHAN_W+1)'(1 << CHAN_W) - {1'b0, alpha_weight};
   assign blend_sum  = (2*CHAN_W+1)'(dst) * (2*CHAN_W+1)'(inv_weight)
                     + (2*CHAN_W+1)'(src) * (2*CHAN_W+1)'(alpha_weight);
   assign add_sum    = {1'b0, dst} + {1'b0, src};

   always_comb begin
      unique case (blend_mode)
         MODE_ALPHA:   result_in = blend_sum[2*CHAN_W-1:CHAN_W];
         MODE_AVERAGE: result_in = (dst >> 1) + (src >> 1);
         MODE_ADD_SAT: result_in = add_sum[CHAN_W] ? CHAN_MAX : add_sum[CHAN_W-1:0];
         MODE_DARKEN:  result_in = (src < dst) ? src : dst;
         MODE_INVERT:  result_in = CHAN_MAX - dst;
         default:      result_in = dst;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/pc_merge.sv]
`default_nettype none

module pc_merge
   import pc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  lane_valid,
   input  wire chan_type lane_red,
   input  wire chan_type lane_green,
   input  wire chan_type lane_blue,
   output logic       advance,
   pc_rsp_if.source   rsp_bus
);

   logic     valid_ff;
   logic     valid_in;
   chan_type red_ff;
   chan_type green_ff;
   chan_type blue_ff;

   assign advance  = !valid_ff || rsp_bus.ready;
   assign valid_in = advance ? lane_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= lane_red;
         green_ff <= lane_green;
         blue_ff  <= lane_blue;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.out_red   = red_ff;
   assign rsp_bus.out_green = green_ff;
   assign rsp_bus.out_blue  = blue_ff;

endmodule

`default_nettype wire

[rtl/pixel_compositor_top.sv]
// channel   dir  handshake          payload
// req_bus   in   valid/ready        dst_red/green/blue, src_red/green/blue
// rsp_bus   out  valid/ready        out_red/green/blue
// csr       in   APB psel/penable   paddr[4:2] register, pwdata, prdata
//
// One request per clock while rsp_bus is ready. Stages: lane register, then
// output register. Three channel lanes run side by side in the first stage.
// Synchronous active-high reset clears the valid flags and the CSR fields.
// A stalled response holds; requests keep flowing until both stages are full.
`default_nettype none

module pixel_compositor_top
   import pc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   pc_req_if.sink                 req_bus,
   pc_rsp_if.source               rsp_bus,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type  cfg;
   logic     lane_valid_ff;
   logic     lane_valid_in;
   logic     advance;
   logic     take;
   chan_type opnd_red;
   chan_type opnd_green;
   chan_type opnd_blue;
   chan_type lane_red;
   chan_type lane_green;
   chan_type lane_blue;

   pc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign take          = !lane_valid_ff || advance;
   assign req_bus.ready = take;
   assign lane_valid_in = take ? req_bus.valid : lane_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
      end
   end

   assign opnd_red   = cfg.use_constant_colour ? cfg.const_red   : req_bus.src_red;
   assign opnd_green = cfg.use_constant_colour ? cfg.const_green : req_bus.src_green;
   assign opnd_blue  = cfg.use_constant_colour ? cfg.const_blue  : req_bus.src_blue;

   pc_lane u_lane_red (
      .clock        (clock),
      .enable       (take),
      .blend_mode   (cfg.blend_mode),
      .alpha_weight (cfg.alpha_weight),
      .dst          (req_bus.dst_red),
      .src          (opnd_red),
      .result       (lane_red)
   );

   pc_lane u_lane_green (
      .clock        (clock),
      .enable       (take),
      .blend_mode   (cfg.blend_mode),
      .alpha_weight (cfg.alpha_weight),
      .dst          (req_bus.dst_green),
      .src          (opnd_green),
      .result       (lane_green)
   );

   pc_lane u_lane_blue (
      .clock        (clock),
      .enable       (take),
      .blend_mode   (cfg.blend_mode),
      .alpha_weight (cfg.alpha_weight),
      .dst          (req_bus.dst_blue),
      .src          (opnd_blue),
      .result       (lane_blue)
   );

   pc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (lane_valid_ff),
      .lane_red   (lane_red),
      .lane_green (lane_green),
      .lane_blue  (lane_blue),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import pc_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int LONG_HOLD     = 80;
   localparam int IDLE_PERCENT  = 37;
   localparam int RANDOM_PHASES = 15;
   localparam int PHASE_ITEMS   = 30;
   localparam int DRAIN_CYCLES  = 4;

   // indexes past the register list; writes there must be dropped
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      chan_type dst_red;
      chan_type dst_green;
      chan_type dst_blue;
      chan_type src_red;
      chan_type src_green;
      chan_type src_blue;
   } pixel_pair_type;

   typedef struct packed {
      chan_type out_red;
      chan_type out_green;
      chan_type out_blue;
   } rgb_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   pc_req_if req_bus ();
   pc_rsp_if rsp_bus ();

   pixel_compositor_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cfg_type        model_cfg;
   pixel_pair_type pending_pixels[$];
   rgb_type        expected_colours[$];

   logic req_taken;
   bit   calm;
   int   holds_asked;
   int   holds_served;
   int   hold_left;
   int   stuck_cycles;
   int   errors;
   int   requests_seen;
   int   results_seen;
   int   settings_applied;
   logic [7:0] modes_seen;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic chan_type blend_channel(chan_type d, chan_type s);
      logic [16:0] weighted;
      logic [8:0]  total;
      case (model_cfg.blend_mode)
         MODE_ALPHA: begin
            weighted = 17'(d) * (17'd256 - 17'(model_cfg.alpha_weight))
                     + 17'(s) * 17'(model_cfg.alpha_weight);
            return weighted[15:8];
         end
         MODE_AVERAGE: return (d >> 1) + (s >> 1);
         MODE_ADD_SAT: begin
            total = 9'(d) + 9'(s);
            return total[8] ? CHAN_MAX : total[7:0];
         end
         MODE_DARKEN: return (s < d) ? s : d;
         MODE_INVERT: return CHAN_MAX - d;
         default: return d;
      endcase
   endfunction

   function automatic rgb_type compose_pixel(pixel_pair_type p);
      rgb_type  c;
      chan_type sr;
      chan_type sg;
      chan_type sb;
      if (model_cfg.use_constant_colour) begin
         sr = model_cfg.const_red;
         sg = model_cfg.const_green;
         sb = model_cfg.const_blue;
      end else begin
         sr = p.src_red;
         sg = p.src_green;
         sb = p.src_blue;
      end
      c.out_red   = blend_channel(p.dst_red, sr);
      c.out_green = blend_channel(p.dst_green, sg);
      c.out_blue  = blend_channel(p.dst_blue, sb);
      return c;
   endfunction

   function automatic chan_type rand_chan();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // sender: a request stays up until taken
   always @(negedge clock) begin : feed
      pixel_pair_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_pixels.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            nxt = pending_pixels.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.dst_red   <= nxt.dst_red;
            req_bus.dst_green <= nxt.dst_green;
            req_bus.dst_blue  <= nxt.dst_blue;
            req_bus.src_red   <= nxt.src_red;
            req_bus.src_green <= nxt.src_green;
            req_bus.src_blue  <= nxt.src_blue;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served < holds_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin : watch
      pixel_pair_type got;
      rgb_type        want;
      logic           req_fire;
      logic           rsp_fire;
      req_fire = !reset && req_bus.valid && req_bus.ready;
      rsp_fire = !reset && rsp_bus.valid && rsp_bus.ready;
      req_taken <= req_fire;
      if (req_fire) begin
         got.dst_red   = req_bus.dst_red;
         got.dst_green = req_bus.dst_green;
         got.dst_blue  = req_bus.dst_blue;
         got.src_red   = req_bus.src_red;
         got.src_green = req_bus.src_green;
         got.src_blue  = req_bus.src_blue;
         expected_colours.push_back(compose_pixel(got));
         requests_seen++;
      end
      if (rsp_fire) begin
         results_seen++;
         if (expected_colours.size() == 0) begin
            $display("%0t: unexpected result %h %h %h", $time,
                     rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue);
            errors++;
         end else begin
            want = expected_colours.pop_front();
            if (rsp_bus.out_red !== want.out_red) begin
               $display("%0t: out_red expected %0d got %0d", $time,
                        want.out_red, rsp_bus.out_red);
               errors++;
            end
            if (rsp_bus.out_green !== want.out_green) begin
               $display("%0t: out_green expected %0d got %0d", $time,
                        want.out_green, rsp_bus.out_green);
               errors++;
            end
            if (rsp_bus.out_blue !== want.out_blue) begin
               $display("%0t: out_blue expected %0d got %0d", $time,
                        want.out_blue, rsp_bus.out_blue);
               errors++;
            end
         end
      end
      if (req_fire || rsp_fire || reset) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                  stuck_cycles, expected_colours.size());
         $display("pixel_compositor_top: mismatch");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] index, input chan_type field);
      logic [DATA_W-1:0] word;
      word = $urandom;
      word[CHAN_W-1:0] = field;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = word;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      case (index)
         REG_BLEND_MODE:   model_cfg.blend_mode = word[MODE_W-1:0];
         REG_ALPHA_WEIGHT: model_cfg.alpha_weight = word[CHAN_W-1:0];
         REG_USE_CONST:    model_cfg.use_constant_colour = word[0];
         REG_CONST_RED:    model_cfg.const_red = word[CHAN_W-1:0];
         REG_CONST_GREEN:  model_cfg.const_green = word[CHAN_W-1:0];
         REG_CONST_BLUE:   model_cfg.const_blue = word[CHAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [MODE_W-1:0] mode, input chan_type alpha,
                                 input logic use_const, input bit spare);
      csr_write(REG_BLEND_MODE, 8'(mode));
      csr_write(REG_ALPHA_WEIGHT, alpha);
      csr_write(REG_USE_CONST, 8'(use_const));
      csr_write(REG_CONST_RED, rand_chan());
      csr_write(REG_CONST_GREEN, rand_chan());
      csr_write(REG_CONST_BLUE, rand_chan());
      if (spare) begin
         csr_write(REG_SPARE_LO, rand_chan());
         csr_write(REG_SPARE_HI, rand_chan());
      end
      modes_seen[model_cfg.blend_mode] = 1'b1;
      settings_applied++;
   endtask

   // checked at the rising edge, where the sender's outputs are settled
   task automatic drain();
      @(posedge clock);
      while (pending_pixels.size() > 0 || req_bus.valid || expected_colours.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      p.dst_red   = rand_chan();
      p.dst_green = rand_chan();
      p.dst_blue  = rand_chan();
      p.src_red   = rand_chan();
      p.src_green = rand_chan();
      p.src_blue  = rand_chan();
      return p;
   endfunction

   initial begin : stimulus
      logic [MODE_W-1:0] mode;
      chan_type          alpha;
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_bus.valid = 1'b0;
      req_bus.dst_red   = '0;
      req_bus.dst_green = '0;
      req_bus.dst_blue  = '0;
      req_bus.src_red   = '0;
      req_bus.src_green = '0;
      req_bus.src_blue  = '0;
      rsp_bus.ready = 1'b0;
      req_taken     = 1'b0;
      calm          = 1'b0;
      holds_asked   = 0;
      holds_served  = 0;
      hold_left     = 0;
      stuck_cycles  = 0;
      errors        = 0;
      requests_seen = 0;
      results_seen  = 0;
      settings_applied = 0;
      modes_seen    = '0;
      model_cfg     = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every mode, undefined ones included, on extreme pixels
      for (int m = 0; m < 8; m++) begin
         apply_settings(MODE_W'(m), 8'hFF, 1'b0, 1'b0);
         pending_pixels.push_back({8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F});
         pending_pixels.push_back({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00});
         pending_pixels.push_back({8'h01, 8'h7F, 8'hFE, 8'h80, 8'hFF, 8'h01});
         drain();
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 8) begin
            mode = MODE_W'(p);
         end else if (p == 8) begin
            mode = MODE_ALPHA;
         end else if ($urandom_range(0, 9) < 8) begin
            mode = MODE_W'($urandom_range(0, 4));
         end else begin
            mode = MODE_W'($urandom_range(5, 7));
         end
         alpha = (p == 0) ? 8'h00 : (p == 8) ? 8'hFF : rand_chan();
         apply_settings(mode, alpha, 1'(p % 3 == 1), p % 4 == 2);
         calm = (p == 6);
         if (p == 3)
            holds_asked++;
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_pixels.push_back(random_pair());
         drain();
         calm = 1'b0;
      end

      $display("covered %0d requests, %0d results, %0d register settings", requests_seen,
               results_seen, settings_applied);
      $display("blend modes exercised (bit per mode): %b", modes_seen);
      if (errors == 0) begin
         $display("pixel_compositor_top: match");
      end else begin
         $display("pixel_compositor_top: mismatch");
      end
      $finish;
   end

endmodule
